### hw/rtl/iew_pkg.sv
`default_nettype none

package iew_pkg;

    localparam int NumW  = 31;
    localparam int DigN  = 10;
    localparam int BcdW  = 4 * DigN;
    localparam int TokW  = 5;
    localparam int CntW  = $clog2(NumW);

    localparam logic [TokW-1:0] TokZero      = 5'd0;
    localparam logic [TokW-1:0] TokTeenBase  = 5'd10;
    localparam logic [TokW-1:0] TokTensBase  = 5'd18;
    localparam logic [TokW-1:0] TokHundred   = 5'd28;
    localparam logic [TokW-1:0] TokScaleBase = 5'd28;

    // Finished decimal digits, handed from the converter to the token sequencer.
    typedef struct packed {
        logic            valid;
        logic [BcdW-1:0] digits;
    } iew_bcd_res_t;

endpackage

`default_nettype wire

### hw/rtl/iew_if.sv
`default_nettype none

interface iew_num_if;
    logic                        valid;
    logic                        ready;
    logic [iew_pkg::NumW-1:0]    number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface iew_tok_if;
    logic                        valid;
    logic                        ready;
    logic [iew_pkg::TokW-1:0]    word;
    logic                        last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/iew_bcd.sv
`default_nettype none

module iew_bcd (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [iew_pkg::NumW-1:0]   number,
    output logic                            busy,
    output iew_pkg::iew_bcd_res_t           res
);

    localparam logic [iew_pkg::CntW-1:0] LastShift = iew_pkg::CntW'(iew_pkg::NumW - 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [iew_pkg::CntW-1:0]     cnt_reg, cnt_next;
    logic [iew_pkg::NumW-1:0]     bin_reg, bin_next;
    logic [iew_pkg::BcdW-1:0]     bcd_reg, bcd_next;
    logic [iew_pkg::BcdW-1:0]     adj;

    // Shift-and-add-three: every digit of five or more is corrected before the shift.
    always_comb
    begin
        for (int i = 0; i < iew_pkg::DigN; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = number;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[iew_pkg::BcdW-2:0], bin_reg[iew_pkg::NumW-1]};
            bin_next = {bin_reg[iew_pkg::NumW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastShift)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy       = busy_reg | done_reg;
    assign res.valid  = done_reg;
    assign res.digits = bcd_reg;

endmodule

`default_nettype wire

### hw/rtl/iew_emit.sv
`default_nettype none

module iew_emit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire iew_pkg::iew_bcd_res_t  bcd,
    output logic                        busy,
    iew_tok_if.source                   tok
);

    typedef enum logic [2:0] {
        P_ZERO,
        P_HUND,
        P_HWORD,
        P_TENS,
        P_UNITS,
        P_SCALE
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [1:0]                   grp_reg, grp_next;
    logic                         busy_reg, busy_next;
    logic [iew_pkg::BcdW-1:0]     dig_reg, dig_next;
    logic                         out_valid_reg, out_valid_next;
    logic [iew_pkg::TokW-1:0]     word_reg, word_next;
    logic                         last_reg, last_next;

    logic [11:0]                  gsel;
    logic [3:0]                   h, t, u;
    logic [3:0]                   nz;
    logic                         lower_nz;
    logic                         step;
    logic                         emit;
    logic                         tl;
    logic [iew_pkg::TokW-1:0]     tw;

    always_comb
    begin
        nz[3] = |dig_reg[39:36];
        nz[2] = |dig_reg[35:24];
        nz[1] = |dig_reg[23:12];
        nz[0] = |dig_reg[11:0];
        case (grp_reg)
            2'd3:    gsel = {8'd0, dig_reg[39:36]};
            2'd2:    gsel = dig_reg[35:24];
            2'd1:    gsel = dig_reg[23:12];
            default: gsel = dig_reg[11:0];
        endcase
        case (grp_reg)
            2'd3:    lower_nz = |nz[2:0];
            2'd2:    lower_nz = |nz[1:0];
            2'd1:    lower_nz = nz[0];
            default: lower_nz = 1'b0;
        endcase
        h = gsel[11:8];
        t = gsel[7:4];
        u = gsel[3:0];
    end

    assign step = busy_reg && (!out_valid_reg || tok.ready);

    always_comb
    begin
        phase_next     = phase_reg;
        grp_next       = grp_reg;
        busy_next      = busy_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg && !tok.ready;
        word_next      = word_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        tw             = iew_pkg::TokZero;
        tl             = 1'b0;

        if (bcd.valid)
        begin
            busy_next  = 1'b1;
            grp_next   = 2'd3;
            dig_next   = bcd.digits;
            phase_next = (bcd.digits == '0) ? P_ZERO : P_HUND;
        end
        else if (step)
        begin
            case (phase_reg)
                P_ZERO:
                begin
                    emit = 1'b1;
                    tw   = iew_pkg::TokZero;
                    tl   = 1'b1;
                end
                P_HUND:
                begin
                    // An all-zero group gives no tokens, not even its scale word.
                    if (!nz[grp_reg])
                    begin
                        grp_next = grp_reg - 2'd1;
                    end
                    else
                    begin
                        emit       = (h != 4'd0);
                        tw         = {1'b0, h};
                        phase_next = P_HWORD;
                    end
                end
                P_HWORD:
                begin
                    emit       = (h != 4'd0);
                    tw         = iew_pkg::TokHundred;
                    tl         = (t == 4'd0) && (u == 4'd0) && (grp_reg == 2'd0);
                    phase_next = P_TENS;
                end
                P_TENS:
                begin
                    emit = (t != 4'd0) || (u != 4'd0);
                    if (t inside {[4'd2:4'd9]})
                    begin
                        tw = iew_pkg::TokTensBase + {1'b0, t};
                        tl = (u == 4'd0) && (grp_reg == 2'd0);
                    end
                    else if (t == 4'd1)
                    begin
                        tw = iew_pkg::TokTeenBase + {1'b0, u};
                        tl = (grp_reg == 2'd0);
                    end
                    else
                    begin
                        tw = {1'b0, u};
                        tl = (grp_reg == 2'd0);
                    end
                    phase_next = P_UNITS;
                end
                P_UNITS:
                begin
                    emit       = (t inside {[4'd2:4'd9]}) && (u != 4'd0);
                    tw         = {1'b0, u};
                    tl         = (grp_reg == 2'd0);
                    phase_next = P_SCALE;
                end
                P_SCALE:
                begin
                    emit = (grp_reg != 2'd0);
                    tw   = iew_pkg::TokScaleBase + {3'b000, grp_reg};
                    tl   = !lower_nz;
                    if (grp_reg == 2'd0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        grp_next   = grp_reg - 2'd1;
                        phase_next = P_HUND;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase

            if (emit)
            begin
                out_valid_next = 1'b1;
                word_next      = tw;
                last_next      = tl;
                if (tl)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_ZERO;
            grp_reg       <= 2'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            word_reg      <= iew_pkg::TokZero;
            last_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            grp_reg       <= grp_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            word_reg      <= word_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign busy      = busy_reg;
    assign tok.valid = out_valid_reg;
    assign tok.word  = word_reg;
    assign tok.last  = last_reg;

endmodule

`default_nettype wire

### hw/rtl/integer_to_english_word_tokens_unit.sv
// Sequence: after the number's transfer come 31 shift-and-add-three steps, one handoff,
// then one to six sequencer steps before the first word token is shown.
// Pacing: one number at a time; the sequencer takes up to 19 steps over four digit groups,
// one token at most per step, and output stalls hold it; a new number is taken once the last token is registered.
// Reset: rst_n clears all control state asynchronously; the block comes up idle.
`default_nettype none

module integer_to_english_word_tokens_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    iew_num_if.sink     num_ch,
    iew_tok_if.source   word_ch
);

    logic                    bcd_busy;
    logic                    emit_busy;
    logic                    start;
    iew_pkg::iew_bcd_res_t   bcd_res;

    assign num_ch.ready = !bcd_busy && !emit_busy;
    assign start        = num_ch.valid && num_ch.ready;

    iew_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (num_ch.number),
        .busy   (bcd_busy),
        .res    (bcd_res)
    );

    iew_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .bcd   (bcd_res),
        .busy  (emit_busy),
        .tok   (word_ch)
    );

endmodule

`default_nettype wire

### hw/rtl/iew_checker.sv
`default_nettype none

module iew_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [iew_pkg::TokW-1:0]   out_word,
    input wire logic                       out_last
);

    // A stalled token holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
        else $error("word token changed while stalled");

    // One number at a time: the unit is busy right after a transfer.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    // While idle, at most the final token of the previous number may still wait.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_last)
        else $error("input ready while a number is still being read out");

    // The Zero token only stands alone.
    a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word == iew_pkg::TokZero) |-> out_last)
        else $error("Zero token without last mark");

endmodule

bind integer_to_english_word_tokens_unit iew_checker u_iew_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num_ch.valid),
    .in_ready  (num_ch.ready),
    .out_valid (word_ch.valid),
    .out_ready (word_ch.ready),
    .out_word  (word_ch.word),
    .out_last  (word_ch.last)
);

`default_nettype wire
